@@ rtl/core/b64_pkg.sv @@
// Shared types, constants and alphabet functions for the Base64 stream codec.
`timescale 1ns / 1ps

package b64_pkg;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int  GRP_MAX  = 4;
    localparam int  GRP_CNTW = 3;
    localparam int  GRP_IDXW = 2;

    localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] REG_DIRECTION = 2'd0;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       bad;
    } t_b64_res;

    typedef struct packed {
        logic [GRP_CNTW-1:0]        cnt;
        t_b64_res [GRP_MAX-1:0]     res;
    } t_b64_grp;

    // 6-bit value to alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)      sextet_char = 8'h41 + w;
        else if (v < 6'd52) sextet_char = 8'h61 + w - 8'd26;
        else if (v < 6'd62) sextet_char = 8'h30 + w - 8'd52;
        else if (v == 6'd62) sextet_char = 8'h2B;
        else                 sextet_char = 8'h2F;
    endfunction

    // alphabet character to 6-bit value; bit 6 set means not in the alphabet
    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      char_value = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) char_value = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) char_value = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)               char_value = 7'd62;
        else if (c == 8'h2F)               char_value = 7'd63;
        else                               char_value = 7'd64;
    endfunction

endpackage

@@ rtl/core/b64_core.sv @@
// Message state and per-item encode/decode logic; produces a group of up to four results.
`timescale 1ns / 1ps

module b64_core import b64_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_dir,
    input  logic       i_clear,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_b64_grp   o_grp
);

    logic [15:0] r_buf, n_buf;
    logic [2:0]  r_held, n_held;
    logic        r_pad, n_pad;
    logic        r_err, n_err;

    logic [23:0] enc_v;
    logic [1:0]  enc_pads;
    logic        enc_emit;
    logic [6:0]  dec_val;
    logic [3:0]  dec_bits;
    logic [15:0] dec_shift;
    logic        dec_got;
    t_b64_grp    grp;

    always_comb begin
        n_buf     = r_buf;
        n_held    = r_held;
        n_pad     = r_pad;
        n_err     = r_err;
        grp       = '0;
        enc_v     = '0;
        enc_pads  = 2'd0;
        enc_emit  = 1'b0;
        dec_val   = char_value(i_byte);
        dec_bits  = {1'b0, r_held} + 4'd6;
        dec_shift = '0;
        dec_got   = 1'b0;

        if (i_dir == DIR_ENCODE) begin
            if (r_held >= 3'd2) begin
                // third byte of a group: four characters out
                enc_v    = {r_buf, i_byte};
                enc_emit = 1'b1;
                n_buf    = '0;
                n_held   = 3'd0;
            end else begin
                if (r_held == 3'd0) begin
                    n_buf  = {8'h00, i_byte};
                    n_held = 3'd1;
                end else begin
                    n_buf  = {r_buf[7:0], i_byte};
                    n_held = 3'd2;
                end
                if (i_last) begin
                    // short final group, padded to four
                    enc_emit = 1'b1;
                    if (r_held == 3'd0) begin
                        enc_v    = {i_byte, 16'h0000};
                        enc_pads = 2'd2;
                    end else begin
                        enc_v    = {r_buf[7:0], i_byte, 8'h00};
                        enc_pads = 2'd1;
                    end
                end
            end
            if (enc_emit) begin
                grp.cnt = 3'd4;
                for (int k = 0; k < GRP_MAX; k++) begin
                    grp.res[k].valid = 1'b1;
                    grp.res[k].bad   = 1'b0;
                    grp.res[k].last  = (k == GRP_MAX - 1) ? i_last : 1'b0;
                    if (k >= GRP_MAX - int'(enc_pads))
                        grp.res[k].data = CH_PAD;
                    else
                        grp.res[k].data = sextet_char(enc_v[23 - 6*k -: 6]);
                end
            end
        end else begin
            if (!r_pad && !r_err) begin
                if (i_byte == CH_PAD) begin
                    n_pad = 1'b1;
                end else if (i_byte == CH_CR || i_byte == CH_LF ||
                             i_byte == CH_SPACE || i_byte == CH_TAB) begin
                    n_pad = r_pad;
                end else if (dec_val[6]) begin
                    n_err = 1'b1;
                end else begin
                    n_buf = {r_buf[9:0], dec_val[5:0]};
                    if (dec_bits >= 4'd8) begin
                        dec_got   = 1'b1;
                        dec_shift = n_buf >> (dec_bits - 4'd8);
                        n_held    = 3'(dec_bits - 4'd8);
                    end else begin
                        n_held    = dec_bits[2:0];
                    end
                end
            end
            if (dec_got || i_last) begin
                grp.cnt          = 3'd1;
                grp.res[0].data  = dec_got ? dec_shift[7:0] : 8'h00;
                grp.res[0].valid = dec_got;
                grp.res[0].last  = i_last;
                grp.res[0].bad   = i_last ? n_err : 1'b0;
            end
        end

        // end of message: start the next one clean
        if (i_last) begin
            n_buf  = '0;
            n_held = 3'd0;
            n_pad  = 1'b0;
            n_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_buf  <= '0;
            r_held <= '0;
            r_pad  <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_step) begin
            r_buf  <= n_buf;
            r_held <= n_held;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

    assign o_grp = grp;

endmodule

@@ rtl/core/b64_obuf.sv @@
// Result group buffer; hands results to the output stream one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module b64_obuf import b64_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_b64_grp   i_grp,
    output logic       o_can_load,
    output logic       o_valid,
    input  logic       i_ready,
    output t_b64_res   o_res
);

    t_b64_res            r_res [GRP_MAX];
    logic [GRP_CNTW-1:0] r_cnt;
    logic [GRP_IDXW-1:0] r_idx;
    logic                pop;

    assign o_valid    = (r_cnt != '0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == '0) || (r_cnt == GRP_CNTW'(1) && i_ready);
    assign o_res      = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
            r_idx <= '0;
        end else if (pop) begin
            r_cnt <= r_cnt - GRP_CNTW'(1);
            r_idx <= r_idx + GRP_IDXW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < GRP_MAX; k++)
                r_res[k] <= i_grp.res[k];
        end
    end

endmodule

@@ rtl/core/base64_stream_codec.sv @@
// Top level of the Base64 stream codec: ports, config register, input stage.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+--------------------------------------
//  in       | s_tvalid s_tready s_tdata s_tlast| tdata[7:0] in_byte, tlast in_last
//  out      | m_tvalid m_tready m_tdata m_tlast| tdata[7:0] out_byte, tlast out_last,
//           | m_tuser                         | tuser[0] out_valid, tuser[1] bad_char
//  config   | psel penable pwrite paddr pwdata| addr 0: direction (0 encode, 1 decode)
//           | prdata pready                   |
//
// An item is registered on accept and processed once the result buffer can take
// its group. Items that emit nothing leave the buffer free for the next item; an
// item that emits a group of four holds the input until that group has drained.
// Reset (synchronous, active low) clears direction to encode and all message state.
// A direction write also clears message state. Output stalls back up into the input
// stage; the input register still takes one item while a group drains.
`timescale 1ns / 1ps

module base64_stream_codec import b64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [0] out_valid, [1] bad_char
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_dir;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       cfg_wr;
    logic       cfg_dir_wr;
    logic       can_load;
    logic       step;
    t_b64_grp   grp;
    t_b64_res   res;

    // APB: zero wait states
    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_dir_wr = cfg_wr && (paddr[2] == REG_DIRECTION[0]) && (paddr[1:0] == 2'b00);
    assign prdata     = (paddr == 3'b000) ? {31'b0, r_dir} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
        end else if (cfg_dir_wr) begin
            r_dir <= pwdata[0];
        end
    end

    // input register: the held item moves on when the result buffer has room
    assign step     = r_in_valid && can_load;
    assign s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    b64_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dir   (r_dir),
        .i_clear (cfg_dir_wr),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_grp   (grp)
    );

    b64_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_grp      (grp),
        .o_can_load (can_load),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_res      (res)
    );

    assign m_tdata = res.data;
    assign m_tlast = res.last;
    assign m_tuser = {res.bad, res.valid};

endmodule

@@ sim/base64_codec_checker.sv @@
// Predicts Base64 codec results from observed traffic and compares them on the output stream.
`timescale 1ns / 1ps

module base64_codec_checker import b64_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // [7:0] out_byte
    input  logic        i_m_tlast,
    input  logic [1:0]  i_m_tuser,   // [0] out_valid, [1] bad_char
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        dir;
    logic [15:0] held_bits;
    logic [2:0]  held_cnt;
    logic        pad_hit;
    logic        err_hit;
    t_b64_res    expected_q[$];
    int          fail_count = 0;

    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        return ALPHABET[8*(63 - int'(v)) +: 8];
    endfunction

    // 64 means not in the alphabet
    function automatic int value_of(input logic [7:0] c);
        for (int k = 0; k < 64; k++)
            if (symbol_of(6'(k)) == c) return k;
        return 64;
    endfunction

    task automatic clear_message();
        held_bits = '0;
        held_cnt  = '0;
        pad_hit   = 1'b0;
        err_hit   = 1'b0;
    endtask

    task automatic push_result(input logic [7:0] data, input logic valid, input logic last,
                               input logic bad);
        t_b64_res r;
        r.data  = data;
        r.valid = valid;
        r.last  = last;
        r.bad   = bad;
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [23:0] word;
        t_b64_res    tail;
        case (held_cnt)
            3'd0: begin
                held_bits = {8'h00, b};
                held_cnt  = 3'd1;
            end
            3'd1: begin
                held_bits = {held_bits[7:0], b};
                held_cnt  = 3'd2;
            end
            default: begin
                word = {held_bits, b};
                for (int k = 3; k >= 0; k--)
                    push_result(symbol_of(word[6*k +: 6]), 1'b1, 1'b0, 1'b0);
                held_bits = '0;
                held_cnt  = 3'd0;
            end
        endcase
        if (last) begin
            // flush: held+1 symbols, rest padded
            if (held_cnt != 3'd0) begin
                word = (held_cnt == 3'd1) ? {held_bits[7:0], 16'h0000} : {held_bits, 8'h00};
                for (int k = 0; k < 4; k++)
                    if (k <= int'(held_cnt))
                        push_result(symbol_of(word[6*(3-k) +: 6]), 1'b1, 1'b0, 1'b0);
                    else
                        push_result(CH_PAD, 1'b1, 1'b0, 1'b0);
            end
            tail = expected_q[$];
            tail.last = 1'b1;
            expected_q[expected_q.size() - 1] = tail;
            clear_message();
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        int         v;
        int         nbits;
        logic       got;
        logic [7:0] byte_out;
        got      = 1'b0;
        byte_out = 8'h00;
        if (!pad_hit && !err_hit) begin
            case (c)
                CH_PAD: pad_hit = 1'b1;
                CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                end
                default: begin
                    v = value_of(c);
                    if (v > 63) begin
                        err_hit = 1'b1;
                    end else begin
                        nbits     = int'(held_cnt) + 6;
                        held_bits = {held_bits[9:0], 6'(v)};
                        if (nbits >= 8) begin
                            nbits    = nbits - 8;
                            byte_out = 8'(held_bits >> nbits);
                            got      = 1'b1;
                        end
                        held_cnt = 3'(nbits);
                    end
                end
            endcase
        end
        if (got)
            push_result(byte_out, 1'b1, last, last & err_hit);
        else if (last)
            push_result(8'h00, 1'b0, 1'b1, err_hit);
        if (last) clear_message();
    endtask

    always @(posedge i_clk) begin : watch
        t_b64_res seen;
        t_b64_res want;
        if (!i_rst_n) begin
            dir = DIR_ENCODE;
            clear_message();
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && (i_paddr >> 2) == 3'(REG_DIRECTION)) begin
                dir = i_pwdata[0];
                clear_message();
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.data  = i_m_tdata;
                seen.valid = i_m_tuser[0];
                seen.last  = i_m_tlast;
                seen.bad   = i_m_tuser[1];
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result: data %h valid %b last %b bad %b",
                                 $time, seen.data, seen.valid, seen.last, seen.bad);
                end else begin
                    want = expected_q.pop_front();
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected data %h valid %b last %b bad %b",
                                     $time, want.data, want.valid, want.last, want.bad);
                            $display("%0t:           got data %h valid %b last %b bad %b",
                                     $time, seen.data, seen.valid, seen.last, seen.bad);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (dir == DIR_DECODE)
                    decode_char(i_s_tdata, i_s_tlast);
                else
                    encode_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fail_count;
    end

endmodule

@@ sim/base64_stream_codec_test.sv @@
// Stimulus, handshake pacing and verdict for the Base64 stream codec.
`timescale 1ns / 1ps

module base64_stream_codec_test;
    import b64_pkg::*;

    // quiet cycles before the run is declared hung; covers the long receiver hold-off
    localparam int         IDLE_LIMIT      = 3000;
    // settle time after the last result: an item that emits nothing may still be in flight
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         ITEMS_PER_PHASE = 110;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam logic [1:0] REG_UNMAPPED    = 2'd1;   // no register behind this index
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] in_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [7:0] out_byte
    logic        m_tlast;
    logic [1:0]  m_tuser;    // [0] out_valid, [1] bad_char
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          quiet_cycles;
    logic        cur_dir;
    logic [7:0]  message[$];

    base64_stream_codec uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    base64_codec_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, or a counted hold-off when the stimulus asks for one.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Hang detector: nothing accepted on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("base64_stream_codec_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, with random gaps ahead of it; returns at the edge that takes it.
    // tvalid stays high straight into the next item when no gap is drawn.
    task automatic send_item(input logic [7:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_message();
        for (int k = 0; k < message.size(); k++)
            send_item(message[k], k == message.size() - 1);
    endtask

    // Sender pause: first edge lets the checker book the last item, then wait out the results.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high.
    task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({index, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only bit 0 counts; the upper bits get random junk.
    task automatic set_direction(input logic d);
        wait_drained();
        reg_write(REG_DIRECTION, ($urandom() & 32'hFFFF_FFFE) | {31'd0, d});
        cur_dir = d;
    endtask

    function automatic logic [7:0] random_symbol();
        return ALPHABET[8*(63 - int'($urandom_range(0, 63))) +: 8];
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic make_bytes(input int count);
        message.delete();
        for (int k = 0; k < count; k++)
            message.insert(message.size(), 8'($urandom_range(0, 255)));
    endtask

    // Mostly clean Base64 text: blanks sprinkled in, sometimes padding with trailing
    // junk behind it, now and then one arbitrary byte dropped anywhere.
    task automatic make_text(input int symbols);
        logic [7:0] junk;
        message.delete();
        for (int k = 0; k < symbols; k++) begin
            if ($urandom_range(0, 99) < 10) message.insert(message.size(), random_blank());
            message.insert(message.size(), random_symbol());
        end
        if ($urandom_range(0, 99) < 20) begin
            message.insert(message.size(), CH_PAD);
            if ($urandom_range(0, 1) == 1) message.insert(message.size(), CH_PAD);
            if ($urandom_range(0, 1) == 1) message.insert(message.size(), random_symbol());
        end
        if ($urandom_range(0, 99) < 10) message.insert(message.size(), random_blank());
        if ($urandom_range(0, 99) < 8) begin
            junk = 8'($urandom_range(0, 255));
            message.insert($urandom_range(0, message.size()), junk);
        end
    endtask

    initial begin
        int   counted;
        int   len;
        logic next_dir;

        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        hold_cycles   = 0;
        send_idle_pct = 36;
        recv_idle_pct = 83;
        cur_dir       = DIR_ENCODE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed ----
        // encode: one full group with extreme bytes, then one and two bytes left at the end
        set_direction(DIR_ENCODE);
        message = '{8'h00, 8'hFF, 8'h80};
        send_message();
        message = '{8'hFF};
        send_message();
        message = '{8'h01, 8'h7F};
        send_message();
        // a write to an unused address must not flip the direction
        wait_drained();
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        message = '{8'hFB};
        send_message();
        // direction write halfway through a message drops the held byte
        send_item(8'h55, 1'b0);
        set_direction(DIR_ENCODE);
        message = '{8'hC3};
        send_message();

        // decode: clean group
        set_direction(DIR_DECODE);
        message = '{"T", "W", "F", "u"};
        send_message();
        // every blank kind, then padding; the symbol after it is ignored, so a bare end marker
        message = '{"A", CH_SPACE, "/", CH_TAB, CH_CR, "9", CH_LF, "z", CH_PAD, "Q"};
        send_message();
        // bad character: decoding stops, error flagged on the end marker
        message = '{"Q", "*", "Q"};
        send_message();

        // ---- random, three pacing phases ----
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 36 : 0;

            if (phase == 2) begin
                // receiver holds off while a long message keeps coming, so the input backs up
                set_direction(DIR_ENCODE);
                hold_cycles = HOLD_OFF_CYCLES;
                make_bytes(30);
                send_message();
            end

            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                next_dir = logic'($urandom_range(0, 1));
                if (next_dir != cur_dir)
                    set_direction(next_dir);
                else if ($urandom_range(0, 99) < 15)
                    wait_drained();

                if ($urandom_range(0, 99) < 10)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);

                if (cur_dir == DIR_ENCODE)
                    make_bytes(len);
                else
                    make_text(len);
                counted += len;
                send_message();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("base64_stream_codec_test: clean");
        else
            $display("base64_stream_codec_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/b64_pkg.sv
rtl/core/b64_core.sv
rtl/core/b64_obuf.sv
rtl/core/base64_stream_codec.sv
sim/base64_codec_checker.sv
sim/base64_stream_codec_test.sv
